/* rtl/rpncc_pkg.sv */
`default_nettype none
package rpncc_pkg;

  localparam int unsigned ValW = 48;
  localparam int unsigned ManW = 64;

  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StEmpty   = 2'd1;
  localparam logic [1:0] StInvalid = 2'd2;

  localparam logic [1:0] PmIdle = 2'd0;
  localparam logic [1:0] PmInt  = 2'd1;
  localparam logic [1:0] PmFrac = 2'd2;

  localparam logic [63:0] IntCap  = 64'd1000000000000000;
  // largest mantissa that still takes one more digit without wrapping 64 bits
  localparam logic [63:0] FracCap = 64'h1999_9999_9999_9998;
  localparam logic [47:0] MagPos  = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] MagNeg  = 48'h8000_0000_0000;

  // saturate a 64-bit magnitude and apply the sign
  function automatic logic [47:0] sign_mag(input logic [63:0] mag, input logic neg);
    logic [63:0] lim;
    logic [63:0] m;
    lim = neg ? {16'd0, MagNeg} : {16'd0, MagPos};
    m = (mag > lim) ? lim : mag;
    sign_mag = neg ? (48'd0 - m[47:0]) : m[47:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/rpn_character_calculator_unit.sv */
`default_nettype none
// sequence: a number end computes the power of ten, the integer quotient and the fraction
// bits and pushes the value before its ending character is dispatched; '+' and '*' pop two
// operands and push the result, '*' through partial products; newline pops and sends the top
// throughput: one character at a time; the next transfer waits for the previous one
// reset: rst_ni asynchronous active low clears count, parser and halt state;
// stack memory contents are not cleared
module rpn_character_calculator_unit import rpncc_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 32,
  parameter int unsigned FRACTION_BITS = 16,
  parameter int unsigned MAX_FRACTION_DIGITS = 18
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] char_code
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [47:0] m_axis_tdata,  // [47:0] top_value
  output      logic [1:0]  m_axis_tuser   // [1:0] status
);

  rpncc_core #(
    .STACK_DEPTH(STACK_DEPTH),
    .FRACTION_BITS(FRACTION_BITS),
    .MAX_FRACTION_DIGITS(MAX_FRACTION_DIGITS)
  ) u_core (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_char_i(s_axis_tdata),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .res_value_o(m_axis_tdata), .res_status_o(m_axis_tuser)
  );

endmodule
`default_nettype wire

/* rtl/rpncc_core.sv */
`default_nettype none
module rpncc_core import rpncc_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 32,
  parameter int unsigned FRACTION_BITS = 16,
  parameter int unsigned MAX_FRACTION_DIGITS = 18
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [7:0]  in_char_i,
  output      logic        res_valid_o,
  input  wire logic        res_ready_i,
  output      logic [47:0] res_value_o,
  output      logic [1:0]  res_status_o
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned FW = $clog2(MAX_FRACTION_DIGITS + 1);
  // bit counter for the 64 quotient bits and the fraction bits
  localparam int unsigned DW = 7;
  localparam logic [CW-1:0] Depth = CW'(STACK_DEPTH);
  localparam logic [47:0] MinusOne = 48'd0 - (48'd1 << FRACTION_BITS);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_POW   = 14'b00000000000010,
    S_QDIV  = 14'b00000000000100,
    S_FDIV  = 14'b00000000001000,
    S_PUSHN = 14'b00000000010000,
    S_DISP  = 14'b00000000100000,
    S_POPA  = 14'b00000001000000,
    S_POPB  = 14'b00000010000000,
    S_MUL0  = 14'b00000100000000,
    S_MUL1  = 14'b00001000000000,
    S_MUL2  = 14'b00010000000000,
    S_OP    = 14'b00100000000000,
    S_NLRD  = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  logic [47:0] mem [STACK_DEPTH];
  logic [47:0] rdata_q;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [47:0] wdata;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  logic [CW-1:0] cnt_q, cnt_d;
  logic [1:0]    pm_q, pm_d;
  logic [63:0]   man_q, man_d;
  logic          neg_q, neg_d;
  logic [FW-1:0] fd_q, fd_d;
  logic          halt_q, halt_d;
  logic [7:0]    ch_q, ch_d;
  logic [63:0]   p_q, p_d, r_q, r_d, q_q, q_d;
  logic [FW-1:0] i_q, i_d;
  logic [DW-1:0] k_q, k_d;
  logic [47:0]   f_q, f_d;
  logic [47:0]   a_q, a_d, b_q, b_d;
  logic          ae_q, ae_d;
  logic [63:0]   pp_q [4];
  logic [63:0]   pp_d [4];
  logic [95:0]   prod_q, prod_d;
  logic [47:0]   ov_val_q, ov_val_d;
  logic [1:0]    ov_st_q, ov_st_d;
  logic          ovld_q, ovld_d;

  logic        digit;
  logic [3:0]  dv;
  logic [67:0] man10;
  logic [63:0] r2;
  logic [63:0] rq;
  logic        c_plus, c_star, c_nl, c_ws, c_minus;
  logic [47:0] ma, mb;
  logic        pneg;
  logic [48:0] sum;
  logic [63:0] rlo;
  logic        rnd;
  logic [47:0] top_sel;
  logic [47:0] qlim;

  assign digit = (ch_q >= ChZero) && (ch_q <= ChNine);
  assign dv = 4'(ch_q - ChZero);
  assign man10 = {1'b0, man_q, 3'd0} + {3'd0, man_q, 1'd0} + 68'(dv);
  assign r2 = {r_q[62:0], 1'b0};
  // next partial remainder of the quotient division, dividend shifted out of q
  assign rq = {r_q[62:0], q_q[63]};
  assign c_plus = ch_q == ChPlus;
  assign c_star = ch_q == ChStar;
  assign c_nl = ch_q == ChNl;
  assign c_ws = (ch_q == ChSpace) || (ch_q == ChTab);
  assign c_minus = ch_q == ChMinus;
  assign ma = a_q[47] ? 48'd0 - a_q : a_q;
  assign mb = b_q[47] ? 48'd0 - b_q : b_q;
  assign pneg = a_q[47] ^ b_q[47];
  assign sum = {a_q[47], a_q} + {b_q[47], b_q};
  assign rlo = prod_q[FRACTION_BITS +: 64];
  assign rnd = prod_q[FRACTION_BITS-1];
  assign qlim = (neg_q ? MagNeg : MagPos) >> FRACTION_BITS;

  assign in_ready_o = (state_q == S_IDLE) && !ovld_q;
  assign res_valid_o = ovld_q;
  assign res_value_o = ov_val_q;
  assign res_status_o = ov_st_q;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q; pm_d = pm_q; man_d = man_q; neg_d = neg_q; fd_d = fd_q;
    halt_d = halt_q; ch_d = ch_q; p_d = p_q; r_d = r_q; q_d = q_q;
    i_d = i_q; k_d = k_q; f_d = f_q; a_d = a_q; b_d = b_q; ae_d = ae_q;
    pp_d = pp_q; prod_d = prod_q;
    ov_val_d = ov_val_q; ov_st_d = ov_st_q; ovld_d = ovld_q;
    we = 1'b0; waddr = cnt_q[AW-1:0]; wdata = a_q;
    raddr = AW'(cnt_q - CW'(1));
    top_sel = 48'd0;
    if (ovld_q && res_ready_i) ovld_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          ch_d = in_char_i;
          if (!halt_q) state_d = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_IDLE;
        if (pm_q == PmInt && digit) begin
          man_d = (man10 > {4'd0, IntCap}) ? IntCap : man10[63:0];
        end else if (pm_q == PmFrac && digit) begin
          if (fd_q < FW'(MAX_FRACTION_DIGITS) && man_q <= FracCap) begin
            man_d = man10[63:0];
            fd_d = fd_q + FW'(1);
          end
        end else if (pm_q == PmInt && ch_q == ChDot) begin
          pm_d = PmFrac;
        end else if (pm_q != PmIdle) begin
          p_d = 64'd1; i_d = '0; state_d = S_POW;
        end else if (c_ws) begin
          state_d = S_IDLE;
        end else if (c_plus || c_star) begin
          state_d = S_POPA;
        end else if (c_nl) begin
          if (cnt_q != '0) state_d = S_NLRD;
          else begin
            ovld_d = 1'b1; ov_val_d = '0; ov_st_d = StEmpty;
          end
        end else if (digit || c_minus) begin
          pm_d = PmInt; man_d = digit ? 64'(dv) : 64'd0;
          neg_d = !digit; fd_d = '0;
        end else begin
          halt_d = 1'b1; ovld_d = 1'b1; ov_val_d = '0; ov_st_d = StInvalid;
        end
      end
      // power of ten, one factor per cycle
      S_POW: begin
        if (i_q == fd_q) begin
          q_d = man_q; r_d = '0; k_d = '0; state_d = S_QDIV;
        end else begin
          p_d = {p_q[60:0], 3'd0} + {p_q[62:0], 1'b0};
          i_d = i_q + FW'(1);
        end
      end
      // integer quotient, restoring division one bit per cycle over 64 bits
      S_QDIV: begin
        if (rq >= p_q) begin
          r_d = rq - p_q;
          q_d = {q_q[62:0], 1'b1};
        end else begin
          r_d = rq;
          q_d = {q_q[62:0], 1'b0};
        end
        if (k_q == DW'(63)) begin
          k_d = '0; f_d = '0; state_d = S_FDIV;
        end else k_d = k_q + DW'(1);
      end
      S_FDIV: begin
        if (k_q == DW'(FRACTION_BITS)) begin
          state_d = S_PUSHN;
        end else begin
          if (r2 >= p_q) begin
            r_d = r2 - p_q; f_d = {f_q[46:0], 1'b1};
          end else begin
            r_d = r2; f_d = {f_q[46:0], 1'b0};
          end
          k_d = k_q + DW'(1);
        end
      end
      S_PUSHN: begin
        if (q_q > {16'd0, qlim}) a_d = sign_mag({16'd0, neg_q ? MagNeg : MagPos}, neg_q);
        else a_d = sign_mag((q_q << FRACTION_BITS) + {16'd0, f_q}
                            + 64'(r2 >= p_q), neg_q);
        wdata = a_d;
        if (cnt_q < Depth) begin
          we = 1'b1; cnt_d = cnt_q + CW'(1);
        end
        pm_d = PmIdle; man_d = '0; neg_d = 1'b0; fd_d = '0;
        state_d = S_DISP;
      end
      S_POPA: begin
        ae_d = cnt_q == '0;
        if (cnt_q != '0) cnt_d = cnt_q - CW'(1);
        state_d = S_POPB;
      end
      S_POPB: begin
        a_d = ae_q ? MinusOne : rdata_q;
        ae_d = cnt_q == '0;
        if (cnt_q != '0) cnt_d = cnt_q - CW'(1);
        state_d = S_MUL0;
      end
      S_MUL0: begin
        b_d = ae_q ? MinusOne : rdata_q;
        state_d = c_plus ? S_OP : S_MUL1;
      end
      S_MUL1: begin
        pp_d[0] = {32'd0, ma[31:0]} * {32'd0, mb[31:0]};
        pp_d[1] = {32'd0, ma[31:0]} * {48'd0, mb[47:32]};
        pp_d[2] = {48'd0, ma[47:32]} * {32'd0, mb[31:0]};
        pp_d[3] = {48'd0, ma[47:32]} * {48'd0, mb[47:32]};
        state_d = S_MUL2;
      end
      S_MUL2: begin
        prod_d = {32'd0, pp_q[0]} + {pp_q[1], 32'd0} + {pp_q[2], 32'd0}
                 + {pp_q[3][31:0], 64'd0};
        state_d = S_OP;
      end
      S_OP: begin
        if (c_plus) begin
          wdata = (sum[48] != sum[47]) ? (sum[48] ? MagNeg : MagPos) : sum[47:0];
        end else if (prod_q[95:FRACTION_BITS+64] != '0 || rlo > (64'd1 << 62)) begin
          wdata = sign_mag({16'd0, MagNeg}, pneg);
        end else begin
          wdata = sign_mag(rlo + 64'(rnd), pneg);
        end
        if (cnt_q < Depth) begin
          we = 1'b1; cnt_d = cnt_q + CW'(1);
        end
        state_d = S_IDLE;
      end
      S_NLRD: begin
        cnt_d = cnt_q - CW'(1);
        state_d = S_OUT;
      end
      S_OUT: begin
        top_sel = rdata_q;
        ovld_d = 1'b1; ov_val_d = top_sel; ov_st_d = StOk;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; pm_q <= PmIdle; man_q <= '0;
      neg_q <= 1'b0; fd_q <= '0; halt_q <= 1'b0; ovld_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; pm_q <= pm_d; man_q <= man_d;
      neg_q <= neg_d; fd_q <= fd_d; halt_q <= halt_d; ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q <= ch_d; p_q <= p_d; r_q <= r_d; q_q <= q_d; i_q <= i_d; k_q <= k_d;
    f_q <= f_d; a_q <= a_d; b_q <= b_d; ae_q <= ae_d; pp_q <= pp_d;
    prod_q <= prod_d; ov_val_q <= ov_val_d; ov_st_q <= ov_st_d;
  end

endmodule
`default_nettype wire
